// ===== hw/rtl/tbsl_pkg.sv =====
// Shared types and constants of the temperature bias segment lookup.
package tbsl_pkg;

   // Table geometry.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = 5;
   localparam int TEMP_W      = 16;
   localparam int DATA_W      = 32;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 104;

   // Item kinds carried on req_tuser.
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_UPDATE_ENABLE  = 3'd0,
      CSR_ENTRIES_IN_USE = 3'd1,
      CSR_BASE_P         = 3'd2,
      CSR_BASE_Q         = 3'd3,
      CSR_BASE_R         = 3'd4
   } csr_index_type;

   // Segment walk states.
   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_UP,
      WALK_DOWN,
      WALK_FETCH
   } walk_state_type;

   // Three-axis offset as held in one table row.
   typedef struct packed {
      logic signed [DATA_W-1:0] r;
      logic signed [DATA_W-1:0] q;
      logic signed [DATA_W-1:0] p;
   } offset_type;

   // Table write request.
   typedef struct packed {
      logic                     we;
      logic [IDX_W-1:0]         addr;
      logic signed [TEMP_W-1:0] temp;
      offset_type               ofs;
   } table_wr_type;

   // Table read requests, one per memory.
   typedef struct packed {
      logic             bp_re;
      logic [IDX_W-1:0] bp_addr;
      logic             ofs_re;
      logic [IDX_W-1:0] ofs_addr;
   } table_rd_type;

   // Finished walk handed to the output stage.
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] seg;
   } walk_res_type;

endpackage

// ===== hw/rtl/tbsl_store.sv =====
// Breakpoint and offset memories with registered read data.
module tbsl_store
   import tbsl_pkg::*;
(
   input  logic                     clock,
   input  table_wr_type             wr,
   input  table_rd_type             rd,
   output logic signed [TEMP_W-1:0] bp_rdata,
   output offset_type               ofs_rdata
);

   logic signed [TEMP_W-1:0] bp_mem  [MAX_ENTRIES];
   offset_type               ofs_mem [MAX_ENTRIES];
   logic signed [TEMP_W-1:0] bp_rdata_ff;
   offset_type               ofs_rdata_ff;

   // Both memories take a load in the same cycle.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         bp_mem[wr.addr]  <= wr.temp;
         ofs_mem[wr.addr] <= wr.ofs;
      end
   end

   // Read data holds until the next read of that memory.
   always_ff @(posedge clock) begin
      if (rd.bp_re) begin
         bp_rdata_ff <= bp_mem[rd.bp_addr];
      end
      if (rd.ofs_re) begin
         ofs_rdata_ff <= ofs_mem[rd.ofs_addr];
      end
   end

   assign bp_rdata  = bp_rdata_ff;
   assign ofs_rdata = ofs_rdata_ff;

endmodule

// ===== hw/rtl/tbsl_walk.sv =====
// Segment walk sequencer: one breakpoint compare per cycle.
module tbsl_walk
   import tbsl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [TEMP_W-1:0] temp,
   input  logic [COUNT_W-1:0]       entries_in_use,
   input  logic signed [TEMP_W-1:0] bp_rdata,
   input  logic                     out_free,
   output logic                     idle,
   output table_rd_type             rd,
   output walk_res_type             res
);

   walk_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         seg_ff, seg_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [IDX_W-1:0]         last;

   // Highest segment allowed by the entry count, clamped to the table.
   always_comb begin
      if (entries_in_use < COUNT_W'(2)) begin
         last = '0;
      end else if (entries_in_use > COUNT_W'(MAX_ENTRIES)) begin
         last = IDX_W'(MAX_ENTRIES - 2);
      end else begin
         last = IDX_W'(entries_in_use - COUNT_W'(2));
      end
   end

   // State, segment and sample registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
         seg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
   end

   // Next state and memory reads. The read for the next compare is issued
   // in the same cycle as the current compare.
   always_comb begin
      logic [IDX_W-1:0] start_seg;
      logic [IDX_W-1:0] up_seg;
      logic             dn_go;
      logic [IDX_W-1:0] dn_seg;
      logic             fetch_go;
      logic [IDX_W-1:0] fetch_seg;

      state_in  = state_ff;
      seg_in    = seg_ff;
      temp_in   = temp_ff;
      rd        = '0;
      res       = '0;
      start_seg = (seg_ff > last) ? last : seg_ff;
      up_seg    = seg_ff + IDX_W'(1);
      dn_go     = 1'b0;
      dn_seg    = seg_ff;
      fetch_go  = 1'b0;
      fetch_seg = seg_ff;

      case (state_ff)
         WALK_IDLE: begin
            if (start) begin
               temp_in = temp;
               seg_in  = start_seg;
               if (start_seg < last) begin
                  rd.bp_re   = 1'b1;
                  rd.bp_addr = start_seg + IDX_W'(1);
                  state_in   = WALK_UP;
               end else begin
                  dn_go  = 1'b1;
                  dn_seg = start_seg;
               end
            end
         end
         WALK_UP: begin
            // Read data is the breakpoint just above the current segment.
            if (temp_ff > bp_rdata) begin
               if (up_seg < last) begin
                  seg_in     = up_seg;
                  rd.bp_re   = 1'b1;
                  rd.bp_addr = up_seg + IDX_W'(1);
               end else begin
                  dn_go  = 1'b1;
                  dn_seg = up_seg;
               end
            end else begin
               dn_go  = 1'b1;
               dn_seg = seg_ff;
            end
         end
         WALK_DOWN: begin
            // Read data is the breakpoint of the current segment.
            if (temp_ff < bp_rdata) begin
               dn_go  = 1'b1;
               dn_seg = seg_ff - IDX_W'(1);
            end else begin
               fetch_go  = 1'b1;
               fetch_seg = seg_ff;
            end
         end
         WALK_FETCH: begin
            // Offsets are ready; hand over once the output register is free.
            if (out_free) begin
               res.load = 1'b1;
               res.seg  = seg_ff;
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase

      // Enter or continue the downward walk from a given segment.
      if (dn_go) begin
         seg_in = dn_seg;
         if (dn_seg != '0) begin
            rd.bp_re   = 1'b1;
            rd.bp_addr = dn_seg;
            state_in   = WALK_DOWN;
         end else begin
            fetch_go  = 1'b1;
            fetch_seg = dn_seg;
         end
      end

      // Read the offsets of the final segment.
      if (fetch_go) begin
         seg_in      = fetch_seg;
         rd.ofs_re   = 1'b1;
         rd.ofs_addr = fetch_seg;
         state_in    = WALK_FETCH;
      end
   end

   assign idle = (state_ff == WALK_IDLE);

endmodule

// ===== hw/rtl/tbsl_bias.sv =====
// Saturating base-plus-offset adders and the result output register.
module tbsl_bias
   import tbsl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  walk_res_type                res,
   input  offset_type                  ofs,
   input  logic signed [DATA_W-1:0]    base_p,
   input  logic signed [DATA_W-1:0]    base_q,
   input  logic signed [DATA_W-1:0]    base_r,
   input  logic                        rsp_tready,
   output logic                        out_free,
   output logic                        rsp_tvalid,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tuser
);

   logic                     valid_ff, valid_in;
   offset_type               sum_ff, sum_in;
   logic [IDX_W-1:0]         seg_ff;
   logic                     sat_ff, sat_in;

   // Add with 33-bit headroom and clamp to the signed 32-bit range.
   function automatic logic [DATA_W:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0]   s;
      logic [DATA_W:0]   r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         // The top bit is the clamp flag, the rest the clamped value.
         r = s[DATA_W] ? {1'b1, 1'b1, {(DATA_W-1){1'b0}}}
                       : {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = {1'b0, s[DATA_W-1:0]};
      end
      return r;
   endfunction

   // Sums of the three axes.
   always_comb begin
      logic [DATA_W:0] rp;
      logic [DATA_W:0] rq;
      logic [DATA_W:0] rr;
      rp       = sat_add(base_p, ofs.p);
      rq       = sat_add(base_q, ofs.q);
      rr       = sat_add(base_r, ofs.r);
      sum_in.p = rp[DATA_W-1:0];
      sum_in.q = rq[DATA_W-1:0];
      sum_in.r = rr[DATA_W-1:0];
      sat_in   = rp[DATA_W] | rq[DATA_W] | rr[DATA_W];
   end

   assign out_free = !valid_ff || rsp_tready;

   // The result stays valid until it is taken.
   always_comb begin
      valid_in = valid_ff;
      if (res.load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         sum_ff <= sum_in;
         seg_ff <= res.seg;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 3*DATA_W - IDX_W)'(0), seg_ff,
                        sum_ff.r, sum_ff.q, sum_ff.p};
   assign rsp_tuser  = sat_ff;

endmodule

// ===== hw/rtl/temperature_bias_segment_lookup.sv =====
// Top level of the temperature bias segment lookup.
//
//   channel  direction  carries
//   req_     in         load item (breakpoint and offsets) or temperature sample
//   rsp_     out        compensated neutral of three axes, segment, clamp flag
//   csr_     in         write-only register port, no wait
//
// A load item writes one table row.
// A sample is walked one breakpoint compare at a time, as the breakpoint
// memory has a single read port.
// req_tready is high only while no sample is being walked; a finished result
// waits in the output register while the next item is taken.
// Reset is synchronous; the table memories are not cleared.
module temperature_bias_segment_lookup
   import tbsl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Fields from bit 0: entry_index[3:0], temperature[19:4], offset_p[51:20],
   // offset_q[83:52], offset_r[115:84], zero fill.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: kind[0].
   input  logic                   req_tuser,
   // Fields from bit 0: neutral_p[31:0], neutral_q[63:32], neutral_r[95:64],
   // segment_index[99:96], zero fill.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Fields from bit 0: saturated[0].
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [DATA_W-1:0]      csr_wdata
);

   logic                     update_enable_ff;
   logic [COUNT_W-1:0]       entries_in_use_ff;
   logic signed [DATA_W-1:0] base_p_ff;
   logic signed [DATA_W-1:0] base_q_ff;
   logic signed [DATA_W-1:0] base_r_ff;

   logic                     req_accept;
   logic                     walk_start;
   logic                     walk_idle;
   logic                     out_free;
   table_wr_type             wr;
   table_rd_type             rd;
   walk_res_type             res;
   logic signed [TEMP_W-1:0] bp_rdata;
   offset_type               ofs_rdata;
   logic signed [TEMP_W-1:0] req_temp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         update_enable_ff  <= 1'b1;
         entries_in_use_ff <= COUNT_W'(2);
         base_p_ff         <= '0;
         base_q_ff         <= '0;
         base_r_ff         <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UPDATE_ENABLE:  update_enable_ff  <= csr_wdata[0];
            CSR_ENTRIES_IN_USE: entries_in_use_ff <= csr_wdata[COUNT_W-1:0];
            CSR_BASE_P:         base_p_ff         <= csr_wdata;
            CSR_BASE_Q:         base_q_ff         <= csr_wdata;
            CSR_BASE_R:         base_r_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item decode: loads write the table, enabled samples start a walk.
   assign req_tready = walk_idle;
   assign req_accept = req_tvalid && req_tready;
   assign req_temp   = req_tdata[19:4];
   assign walk_start = req_accept && (req_tuser == KIND_SAMPLE) && update_enable_ff;

   always_comb begin
      wr       = '0;
      wr.we    = req_accept && (req_tuser == KIND_LOAD);
      wr.addr  = req_tdata[IDX_W-1:0];
      wr.temp  = req_temp;
      wr.ofs.p = req_tdata[51:20];
      wr.ofs.q = req_tdata[83:52];
      wr.ofs.r = req_tdata[115:84];
   end

   tbsl_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd        (rd),
      .bp_rdata  (bp_rdata),
      .ofs_rdata (ofs_rdata)
   );

   tbsl_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .start          (walk_start),
      .temp           (req_temp),
      .entries_in_use (entries_in_use_ff),
      .bp_rdata       (bp_rdata),
      .out_free       (out_free),
      .idle           (walk_idle),
      .rd             (rd),
      .res            (res)
   );

   tbsl_bias u_bias (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .ofs        (ofs_rdata),
      .base_p     (base_p_ff),
      .base_q     (base_q_ff),
      .base_r     (base_r_ff),
      .rsp_tready (rsp_tready),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hw/rtl/tbsl_checker.sv =====
// Port-level checks of the temperature bias segment lookup, bound to the top level.
module tbsl_checker
   import tbsl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A waiting result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The walk never ends beyond the last usable segment.
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[99:96] != 4'd15)
      else $error("segment index out of range");

   // A load item never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_LOAD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after a load item");

endmodule

bind temperature_bias_segment_lookup tbsl_checker u_tbsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
